>>> hw/rtl/qxmm_pkg.sv
// Shared types and constants for the quad X-frame motor mixer.
package qxmm_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int CMD_W      = 12;
    localparam int MOTOR_W    = 16;
    localparam int CFG_IDX_W  = 2;

    // Motor order: front left, front right, rear left, rear right
    localparam int M_FL = 0;
    localparam int M_FR = 1;
    localparam int M_RL = 2;
    localparam int M_RR = 3;

    typedef logic signed [MOTOR_W-1:0] t_motor;
    typedef logic [CMD_W-1:0]          t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_COMMAND   = 2'd0,
        CFG_MIN_ARMED     = 2'd1,
        CFG_YAW_DIRECTION = 2'd2
    } t_cfg_reg;

    localparam t_cmd   MAX_COMMAND_RST   = 12'd2000;
    localparam t_cmd   MIN_ARMED_RST     = 12'd1150;
    localparam logic   YAW_DIRECTION_RST = 1'b1;
    localparam t_motor FLOOR_RST         = 16'sd1100;
    localparam t_motor CEILING_RST       = 16'sd1900;

    typedef struct packed {
        logic [CMD_W-1:0]        throttle_in;
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
        logic                    flight_enabled;
    } t_in_item;

    typedef struct packed {
        t_motor motor_front_left;
        t_motor motor_front_right;
        t_motor motor_rear_left;
        t_motor motor_rear_right;
        logic   high_limit_active;
        logic   low_limit_active;
    } t_out_item;

endpackage

>>> hw/rtl/qxmm_mix.sv
// X-frame mixer: throttle, roll, pitch and yaw into four motor commands.
module qxmm_mix
    import qxmm_pkg::*;
(
    input  t_in_item i_item,
    input  logic     i_yaw_dir,
    output t_motor   o_mix [NUM_MOTORS]
);

    logic [CMD_W-1:0] abs_yaw;
    t_motor           thr_s;
    t_motor           half_s;
    t_motor           t_s;
    t_motor           roll_s;
    t_motor           pitch_s;
    t_motor           yaw_s;

    always_comb begin
        abs_yaw = i_item.yaw_cmd[CMD_W-1] ? CMD_W'(-i_item.yaw_cmd) : CMD_W'(i_item.yaw_cmd);
        thr_s   = t_motor'({{(MOTOR_W-CMD_W){1'b0}}, i_item.throttle_in});
        half_s  = t_motor'({{(MOTOR_W-CMD_W+1){1'b0}}, abs_yaw[CMD_W-1:1]});
        t_s     = thr_s - half_s;
        roll_s  = t_motor'({{(MOTOR_W-CMD_W){i_item.roll_cmd[CMD_W-1]}}, i_item.roll_cmd});
        pitch_s = t_motor'({{(MOTOR_W-CMD_W){i_item.pitch_cmd[CMD_W-1]}}, i_item.pitch_cmd});
        yaw_s   = i_yaw_dir
                ? t_motor'({{(MOTOR_W-CMD_W){i_item.yaw_cmd[CMD_W-1]}}, i_item.yaw_cmd})
                : '0;
        o_mix[M_FL] = t_s - pitch_s + roll_s - yaw_s;
        o_mix[M_FR] = t_s - pitch_s - roll_s + yaw_s;
        o_mix[M_RL] = t_s + pitch_s + roll_s + yaw_s;
        o_mix[M_RR] = t_s + pitch_s - roll_s - yaw_s;
    end

endmodule

>>> hw/rtl/qxmm_limit.sv
// Limit flags, per-motor floors and ceilings, clamp and motor command store.
module qxmm_limit
    import qxmm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_flight_en,
    input  t_motor i_mix [NUM_MOTORS],
    input  t_cmd   i_max_cmd,
    input  t_cmd   i_min_armed,
    output t_motor o_motor [NUM_MOTORS],
    output logic   o_high,
    output logic   o_low
);

    t_motor r_motor   [NUM_MOTORS];
    t_motor r_floor   [NUM_MOTORS];
    t_motor r_ceiling [NUM_MOTORS];
    logic   r_high;
    logic   r_low;

    t_motor n_floor   [NUM_MOTORS];
    t_motor n_ceiling [NUM_MOTORS];
    t_motor sel       [NUM_MOTORS];
    t_motor max_s;
    t_motor min_s;
    logic   any_high;
    logic   any_low;

    always_comb begin
        max_s    = t_motor'({{(MOTOR_W-CMD_W){1'b0}}, i_max_cmd});
        min_s    = t_motor'({{(MOTOR_W-CMD_W){1'b0}}, i_min_armed});
        any_high = 1'b0;
        any_low  = 1'b0;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            sel[i] = i_flight_en ? i_mix[i] : r_motor[i];
            if (sel[i] >= max_s) begin
                any_high = 1'b1;
            end
            if (sel[i] <= min_s) begin
                any_low = 1'b1;
            end
        end
        for (int i = 0; i < NUM_MOTORS; i++) begin
            n_floor[i]   = r_floor[i];
            n_ceiling[i] = r_ceiling[i];
            if (!any_high && r_high) begin
                n_floor[i] = min_s;
            end else if (any_high && !r_high) begin
                n_floor[i] = sel[i];
            end
            if (!any_low && r_low) begin
                n_ceiling[i] = max_s;
            end else if (any_low && !r_low) begin
                n_ceiling[i] = sel[i];
            end
            if (sel[i] < n_floor[i]) begin
                o_motor[i] = n_floor[i];
            end else if (sel[i] > n_ceiling[i]) begin
                o_motor[i] = n_ceiling[i];
            end else begin
                o_motor[i] = sel[i];
            end
        end
        o_high = any_high;
        o_low  = any_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_motor[i]   <= '0;
                r_floor[i]   <= FLOOR_RST;
                r_ceiling[i] <= CEILING_RST;
            end
            r_high <= 1'b0;
            r_low  <= 1'b0;
        end else if (i_adv) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_motor[i]   <= o_motor[i];
                r_floor[i]   <= n_floor[i];
                r_ceiling[i] <= n_ceiling[i];
            end
            r_high <= any_high;
            r_low  <= any_low;
        end
    end

endmodule

>>> hw/rtl/quad_x_motor_mixer_with_limits_unit.sv
// Top level of the quad X-frame motor mixer with sticky limits.
//
// Input channel: i_in_valid / o_in_stall carry one t_in_item per transaction.
// Output channel: o_out_valid / i_out_stall carry one t_out_item per transaction.
// Configuration: i_cfg_wr_en writes i_cfg_data into the register selected by
// i_cfg_index (max command, min armed, yaw direction); other indexes are
// ignored. Write only while no transaction is in flight.
// Each input transaction produces exactly one output transaction.
// Path: the input register loads at acceptance, then mix, limit update and
// clamp load the result register when the item advances (the result register
// is empty or its contents are being taken).
// Throughput: one transaction per cycle while the output is not stalled; the
// motor store, floors, ceilings and limit flags update in the same cycle the
// result register loads, so the next item already sees them.
// Reset: synchronous, active low; clears both stages, restores register
// defaults, zeroes the motor store, sets floors to 1100 and ceilings to 1900.
// Output stall: the result holds; the input register keeps filling once and
// then stalls the input side until the result is taken.
module quad_x_motor_mixer_with_limits_unit
    import qxmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CMD_W-1:0]     i_cfg_data
);

    t_cmd      r_max_cmd;
    t_cmd      r_min_armed;
    logic      r_yaw_dir;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      adv;
    logic      in_acc;
    t_motor    mix   [NUM_MOTORS];
    t_motor    motor [NUM_MOTORS];
    logic      high;
    logic      low;

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cmd   <= MAX_COMMAND_RST;
            r_min_armed <= MIN_ARMED_RST;
            r_yaw_dir   <= YAW_DIRECTION_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MAX_COMMAND:   r_max_cmd   <= i_cfg_data;
                CFG_MIN_ARMED:     r_min_armed <= i_cfg_data;
                CFG_YAW_DIRECTION: r_yaw_dir   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
        if (adv) begin
            r_out_item.motor_front_left  <= motor[M_FL];
            r_out_item.motor_front_right <= motor[M_FR];
            r_out_item.motor_rear_left   <= motor[M_RL];
            r_out_item.motor_rear_right  <= motor[M_RR];
            r_out_item.high_limit_active <= high;
            r_out_item.low_limit_active  <= low;
        end
    end

    qxmm_mix u_mix (
        .i_item    (r_in_item),
        .i_yaw_dir (r_yaw_dir),
        .o_mix     (mix)
    );

    qxmm_limit u_limit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_flight_en (r_in_item.flight_enabled),
        .i_mix       (mix),
        .i_max_cmd   (r_max_cmd),
        .i_min_armed (r_min_armed),
        .o_motor     (motor),
        .o_high      (high),
        .o_low       (low)
    );

endmodule
